### hw/rtl/ordered_array_list_engine_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered array list engine
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_LIST_ENGINE_UNIT_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ENGINE_UNIT_ASSERT_SVH

`ifndef SYNTH
// check a property every clock while out of reset
`define OALE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check a property every clock, reset included
`define OALE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OALE_ASSERT(lbl, clk, rstn, prop, msg)
`define OALE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### hw/rtl/oale_pkg.sv
// ----------------------------------------------------------------------------
// oale_pkg
// Shared widths, request codes and the result record of the list engine.
// ----------------------------------------------------------------------------
package oale_pkg;

  localparam int OP_W     = 3;
  localparam int POS_W    = 9;
  localparam int DATA_W   = 32;
  localparam int FILL_W   = 9;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  localparam int DEF_CAPACITY = 256;

  // request codes
  localparam logic [OP_W-1:0] OP_INSERT       = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE_AT    = 3'd1;
  localparam logic [OP_W-1:0] OP_READ         = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_VALUE = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND         = 3'd4;
  localparam logic [OP_W-1:0] OP_COUNT        = 3'd5;
  localparam logic [OP_W-1:0] OP_SUM          = 3'd6;

  localparam logic [DATA_W-1:0] NOT_FOUND = '1;

  // one finished result, sequencer to output register
  typedef struct packed {
    logic [FILL_W-1:0] fill_count;
    logic [DATA_W-1:0] result_data;
    logic              ok;
  } res_t;

endpackage

### hw/rtl/oale_ram.sv
// ----------------------------------------------------------------------------
// oale_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module oale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/oale_ctrl.sv
// ----------------------------------------------------------------------------
// oale_ctrl
// Request sequencer: walks the list storage one RAM read per cycle to
// shift, search, count and sum, and keeps the fill count.
// ----------------------------------------------------------------------------
`include "ordered_array_list_engine_unit_assert.svh"

module oale_ctrl import oale_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request side
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [OP_W-1:0]             req_type,
  input  logic [POS_W-1:0]            req_position,
  input  logic [DATA_W-1:0]           req_value,
  // result side
  output logic                        res_valid,
  input  logic                        res_ready,
  output res_t                        res,
  // storage RAM
  output logic                        ram_wr_en,
  output logic [$clog2(CAPACITY)-1:0] ram_wr_addr,
  output logic [DATA_W-1:0]           ram_wr_data,
  output logic [$clog2(CAPACITY)-1:0] ram_rd_addr,
  input  logic [DATA_W-1:0]           ram_rd_data
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_SHUP = 3'd2;
  localparam logic [2:0] S_SHDN = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic              rv_r, rv_nxt;
  logic [AW-1:0]     ra_r, ra_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic              ok_r, ok_nxt;
  logic [DATA_W-1:0] dat_r, dat_nxt;

  logic              req_fire;
  logic [CW-1:0]     pos_ext;
  logic [CW-1:0]     cnt_ext;
  logic              match;
  logic              hit;
  logic              scan_go;
  logic [CNT_W:0]    ptr_inc;
  logic              ram_rd_any;

  assign req_ready = (state_r == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign pos_ext   = CW'(req_position);
  assign cnt_ext   = CW'(cnt_r);

  // compare of the word coming back from the RAM
  assign match   = (ram_rd_data == val_r);
  assign hit     = rv_r && match && ((op_r == OP_FIND) || (op_r == OP_REMOVE_VALUE));
  assign scan_go = (ptr_r < cnt_r) && !hit;
  assign ptr_inc = {1'b0, ptr_r} + (CNT_W + 1)'(1);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    pos_nxt     = pos_r;
    val_nxt     = val_r;
    cnt_nxt     = cnt_r;
    ptr_nxt     = ptr_r;
    rv_nxt      = 1'b0;
    ra_nxt      = ra_r;
    acc_nxt     = acc_r;
    ok_nxt      = ok_r;
    dat_nxt     = dat_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = ra_r;
    ram_wr_data = ram_rd_data;
    ram_rd_addr = ptr_r[AW-1:0];
    ram_rd_any  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (req_fire) begin
          op_nxt  = req_type;
          pos_nxt = pos_ext[CNT_W-1:0];
          val_nxt = req_value;
          acc_nxt = '0;
          ok_nxt  = 1'b0;
          dat_nxt = '0;
          case (req_type)
            OP_INSERT: begin
              if ((pos_ext <= cnt_ext) && (cnt_r < CNT_W'(CAPACITY))) begin
                ok_nxt    = 1'b1;
                ptr_nxt   = cnt_r;
                state_nxt = S_SHUP;
              end else begin
                state_nxt = S_DONE;
              end
            end
            OP_REMOVE_AT: begin
              if (pos_ext < cnt_ext) begin
                ok_nxt    = 1'b1;
                ptr_nxt   = pos_ext[CNT_W-1:0];
                state_nxt = S_SHDN;
              end else begin
                state_nxt = S_DONE;
              end
            end
            OP_READ: begin
              if (pos_ext < cnt_ext) begin
                state_nxt = S_RD;
              end else begin
                dat_nxt   = NOT_FOUND;
                state_nxt = S_DONE;
              end
            end
            OP_REMOVE_VALUE, OP_FIND, OP_COUNT, OP_SUM: begin
              ptr_nxt   = '0;
              state_nxt = S_SCAN;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // linear pass from entry 0, one read per cycle
      S_SCAN: begin
        if (scan_go) begin
          ram_rd_addr = ptr_r[AW-1:0];
          ram_rd_any  = 1'b1;
          ptr_nxt     = ptr_r + CNT_W'(1);
          rv_nxt      = 1'b1;
          ra_nxt      = ptr_r[AW-1:0];
        end
        if (rv_r) begin
          if (op_r == OP_SUM) begin
            acc_nxt = acc_r + ram_rd_data;
          end else if (match) begin
            acc_nxt = acc_r + DATA_W'(1);
          end
        end
        if (hit) begin
          ok_nxt = 1'b1;
          if (op_r == OP_FIND) begin
            dat_nxt   = DATA_W'(ra_r);
            state_nxt = S_DONE;
          end else begin
            ptr_nxt   = CNT_W'(ra_r);
            state_nxt = S_SHDN;
          end
        end else if (!scan_go && !rv_r) begin
          case (op_r)
            OP_FIND: begin
              ok_nxt  = 1'b0;
              dat_nxt = NOT_FOUND;
            end
            OP_COUNT, OP_SUM: begin
              ok_nxt  = 1'b1;
              dat_nxt = acc_r;
            end
            default: begin
              ok_nxt  = 1'b0;
              dat_nxt = '0;
            end
          endcase
          state_nxt = S_DONE;
        end
      end

      // move entries up: read i-1, write i on the next cycle
      S_SHUP: begin
        if (rv_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = ra_r + AW'(1);
          ram_wr_data = ram_rd_data;
        end
        if (ptr_r > pos_r) begin
          ram_rd_addr = AW'(ptr_r - CNT_W'(1));
          ram_rd_any  = 1'b1;
          ptr_nxt     = ptr_r - CNT_W'(1);
          rv_nxt      = 1'b1;
          ra_nxt      = AW'(ptr_r - CNT_W'(1));
        end else if (!rv_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = pos_r[AW-1:0];
          ram_wr_data = val_r;
          cnt_nxt     = cnt_r + CNT_W'(1);
          state_nxt   = S_DONE;
        end
      end

      // move entries down: read i+1, write i on the next cycle
      S_SHDN: begin
        if (rv_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = ra_r - AW'(1);
          ram_wr_data = ram_rd_data;
        end
        if (ptr_inc < {1'b0, cnt_r}) begin
          ram_rd_addr = ptr_inc[AW-1:0];
          ram_rd_any  = 1'b1;
          ptr_nxt     = ptr_inc[CNT_W-1:0];
          rv_nxt      = 1'b1;
          ra_nxt      = ptr_inc[AW-1:0];
        end else if (!rv_r) begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end

      // single-entry read
      S_RD: begin
        if (!rv_r) begin
          ram_rd_addr = pos_r[AW-1:0];
          ram_rd_any  = 1'b1;
          rv_nxt      = 1'b1;
          ra_nxt      = pos_r[AW-1:0];
        end else begin
          ok_nxt    = 1'b1;
          dat_nxt   = ram_rd_data;
          state_nxt = S_DONE;
        end
      end

      // hand the result to the output register
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ptr_r   <= '0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ptr_r   <= ptr_nxt;
      rv_r    <= rv_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    ra_r  <= ra_nxt;
    acc_r <= acc_nxt;
    ok_r  <= ok_nxt;
    dat_r <= dat_nxt;
  end

  assign res_valid       = (state_r == S_DONE);
  assign res.ok          = ok_r;
  assign res.result_data = dat_r;
  assign res.fill_count  = FILL_W'(cnt_r);

  `OALE_ASSERT(a_cnt_cap, clk, rst_n, cnt_r <= CNT_W'(CAPACITY), "fill count above capacity")
  `OALE_ASSERT(a_ptr_cnt, clk, rst_n, ptr_r <= cnt_r, "walk pointer past fill count")
  `OALE_ASSERT(a_no_rw_clash, clk, rst_n, (ram_wr_en && ram_rd_any) |-> (ram_wr_addr != ram_rd_addr), "read and write hit the same entry")
  `OALE_ASSERT(a_rv_busy, clk, rst_n, rv_r |-> ((state_r != S_IDLE) && (state_r != S_DONE)), "read in flight outside a walk")

endmodule

### hw/rtl/ordered_array_list_engine_unit.sv
// One request is in work at a time; the next is accepted the cycle after
// the result enters the output register.
// The single read port of the list RAM sets the pace: one entry per cycle.
// Reset (rst_n low, synchronous) empties the list; RAM contents are kept.
// ----------------------------------------------------------------------------
// ordered_array_list_engine_unit
// Ordered list of signed words with insert, remove, read, find, count, sum.
// ----------------------------------------------------------------------------
module ordered_array_list_engine_unit import oale_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request: [2:0] req_type, [11:3] position, [43:12] item_value
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // result: [0] ok, [32:1] result_data, [41:33] fill_count
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(CAPACITY);

  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [DATA_W-1:0] ram_wr_data;
  logic [AW-1:0]     ram_rd_addr;
  logic [DATA_W-1:0] ram_rd_data;
  logic              out_valid_r;
  res_t              out_res_r;

  oale_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (in_tvalid),
    .req_ready    (in_tready),
    .req_type     (in_tdata[OP_W-1:0]),
    .req_position (in_tdata[OP_W+POS_W-1:OP_W]),
    .req_value    (in_tdata[OP_W+POS_W+DATA_W-1:OP_W+POS_W]),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .ram_wr_en    (ram_wr_en),
    .ram_wr_addr  (ram_wr_addr),
    .ram_wr_data  (ram_wr_data),
    .ram_rd_addr  (ram_rd_addr),
    .ram_rd_data  (ram_rd_data)
  );

  oale_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // output register, takes a result when empty or when the held one is taken
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - $bits(res_t)){1'b0}}, out_res_r};

endmodule
